### rtl/bfds_pkg.sv
package bfds_pkg;

	localparam int WINDOW_BITS_DEF = 16;
	localparam int CNT_NUM         = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	// operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_VOLT = 2'd1;
	localparam logic [1:0] OP_TEMP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_VOLT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_VOLT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_TEMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_TEMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_WIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_WIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_WIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COMM_WIN   = 3'd7;

	// debounce counter slots
	localparam int CNT_VOLT = 0;
	localparam int CNT_TEMP = 1;
	localparam int CNT_OPEN = 2;
	localparam int CNT_COMM = 3;

	// reset values: 2.8 V, 4.2 V, -20.0 C, 60.0 C
	localparam logic [12:0]        UNDER_VOLT_RST = 13'd2800;
	localparam logic [12:0]        OVER_VOLT_RST  = 13'd4200;
	localparam logic signed [11:0] UNDER_TEMP_RST = -12'sd200;
	localparam logic signed [11:0] OVER_TEMP_RST  = 12'sd600;
	localparam logic [15:0]        VOLT_WIN_RST   = 16'd500;
	localparam logic [15:0]        TEMP_WIN_RST   = 16'd1000;
	localparam logic [15:0]        OPEN_WIN_RST   = 16'd1000;
	localparam logic [15:0]        COMM_WIN_RST   = 16'd500;

	typedef struct packed {
		logic [1:0]        operation;
		logic              read_ok;
		logic [12:0]       min_cell_mv;
		logic [12:0]       max_cell_mv;
		logic signed [11:0] min_temp_dc;
		logic signed [11:0] max_temp_dc;
		logic              sensor_open;
		logic              current_ok;
	} bfds_in_t;

	typedef struct packed {
		logic bms_ok;
		logic fault_voltage;
		logic fault_temp;
		logic fault_sensor_open;
		logic fault_comm;
		logic fault_current;
		logic reinit_request;
	} bfds_out_t;

endpackage

### rtl/battery_fault_debounce_supervisor.sv
// Battery health supervisor. Takes one word per cycle unless out_ready stalls it
// (tick, voltage report or temperature report) and returns one status word per
// input word, in order. Each word passes an input register and then a result
// register before its result is presented; with out_ready held high the block
// sustains one word every cycle, the limit being the single state update done
// between the two registers.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle.
// Voltage, temperature, open sensor and comm faults are debounced over tick windows; all faults are non-latching.
module battery_fault_debounce_supervisor #(
	parameter int WINDOW_BITS = bfds_pkg::WINDOW_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bfds_pkg::bfds_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bfds_pkg::bfds_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bfds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfds_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bfds_pkg::*;

	localparam int CMP_W = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;
	localparam logic [WINDOW_BITS-1:0] CNT_MAX = {WINDOW_BITS{1'b1}};

	// configuration registers
	logic [12:0]        under_volt_q, over_volt_q;
	logic signed [11:0] under_temp_q, over_temp_q;
	logic [15:0]        win_q [CNT_NUM];

	// supervisor state
	logic                   voltage_cond_q, temp_cond_q, open_cond_q;
	logic                   last_voltage_ok_q, last_temp_ok_q;
	logic                   comm_lost_q;
	logic [15:0]            comm_lost_ticks_q;
	logic [WINDOW_BITS-1:0] cnt_q [CNT_NUM];

	// pipeline
	logic      valid_s1;
	bfds_in_t  data_s1;
	logic      out_valid_q;
	bfds_out_t out_q;
	logic      advance;

	// next state
	logic                   voltage_cond_n, temp_cond_n, open_cond_n;
	logic                   last_voltage_ok_n, last_temp_ok_n;
	logic                   comm_lost_n;
	logic [15:0]            comm_lost_ticks_n;
	logic [WINDOW_BITS-1:0] cnt_n [CNT_NUM];
	logic [CNT_NUM-1:0]     cond_old, cond_new, fault;
	logic                   reinit;
	logic                   is_tick;
	bfds_out_t              res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			under_volt_q     <= UNDER_VOLT_RST;
			over_volt_q      <= OVER_VOLT_RST;
			under_temp_q     <= UNDER_TEMP_RST;
			over_temp_q      <= OVER_TEMP_RST;
			win_q[CNT_VOLT]  <= VOLT_WIN_RST;
			win_q[CNT_TEMP]  <= TEMP_WIN_RST;
			win_q[CNT_OPEN]  <= OPEN_WIN_RST;
			win_q[CNT_COMM]  <= COMM_WIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UNDER_VOLT: under_volt_q    <= cfg_data[12:0];
				REG_OVER_VOLT:  over_volt_q     <= cfg_data[12:0];
				REG_UNDER_TEMP: under_temp_q    <= $signed(cfg_data[11:0]);
				REG_OVER_TEMP:  over_temp_q     <= $signed(cfg_data[11:0]);
				REG_VOLT_WIN:   win_q[CNT_VOLT] <= cfg_data;
				REG_TEMP_WIN:   win_q[CNT_TEMP] <= cfg_data;
				REG_OPEN_WIN:   win_q[CNT_OPEN] <= cfg_data;
				REG_COMM_WIN:   win_q[CNT_COMM] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_tick = (data_s1.operation == OP_TICK);

		cond_old[CNT_VOLT] = voltage_cond_q;
		cond_old[CNT_TEMP] = temp_cond_q;
		cond_old[CNT_OPEN] = open_cond_q;
		cond_old[CNT_COMM] = comm_lost_q && (comm_lost_ticks_q >= win_q[CNT_COMM]);

		for (int i = 0; i < CNT_NUM; i++) begin
			cnt_n[i] = cnt_q[i];
			if (is_tick && cond_old[i] && cnt_q[i] != CNT_MAX)
				cnt_n[i] = cnt_q[i] + 1'b1;
		end

		comm_lost_ticks_n = comm_lost_ticks_q;
		if (is_tick && comm_lost_q && comm_lost_ticks_q != 16'hFFFF)
			comm_lost_ticks_n = comm_lost_ticks_q + 16'd1;

		voltage_cond_n    = voltage_cond_q;
		temp_cond_n       = temp_cond_q;
		open_cond_n       = open_cond_q;
		last_voltage_ok_n = last_voltage_ok_q;
		last_temp_ok_n    = last_temp_ok_q;
		case (data_s1.operation)
			OP_VOLT: begin
				last_voltage_ok_n = data_s1.read_ok;
				if (data_s1.read_ok)
					voltage_cond_n = (data_s1.min_cell_mv < under_volt_q)
						|| (data_s1.max_cell_mv > over_volt_q);
			end
			OP_TEMP: begin
				last_temp_ok_n = data_s1.read_ok;
				if (data_s1.read_ok) begin
					temp_cond_n = ($signed(data_s1.min_temp_dc) < under_temp_q)
						|| ($signed(data_s1.max_temp_dc) > over_temp_q);
					open_cond_n = data_s1.sensor_open;
				end
			end
			default: ;
		endcase

		// read error episode: first word pulses reinit and restarts the timer
		reinit      = 1'b0;
		comm_lost_n = comm_lost_q;
		if (!last_voltage_ok_n || !last_temp_ok_n) begin
			if (!comm_lost_q) begin
				comm_lost_n       = 1'b1;
				comm_lost_ticks_n = '0;
				reinit            = 1'b1;
			end
		end else begin
			comm_lost_n       = 1'b0;
			comm_lost_ticks_n = '0;
		end

		cond_new[CNT_VOLT] = voltage_cond_n;
		cond_new[CNT_TEMP] = temp_cond_n;
		cond_new[CNT_OPEN] = open_cond_n;
		cond_new[CNT_COMM] = comm_lost_n && (comm_lost_ticks_n >= win_q[CNT_COMM]);

		for (int i = 0; i < CNT_NUM; i++) begin
			if (!cond_new[i])
				cnt_n[i] = '0;
			fault[i] = cond_new[i] && (CMP_W'(cnt_n[i]) >= CMP_W'(win_q[i]));
		end

		res.fault_voltage     = fault[CNT_VOLT];
		res.fault_temp        = fault[CNT_TEMP];
		res.fault_sensor_open = fault[CNT_OPEN];
		res.fault_comm        = fault[CNT_COMM];
		res.fault_current     = !data_s1.current_ok;
		res.reinit_request    = reinit;
		res.bms_ok            = !(|fault) && data_s1.current_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			voltage_cond_q    <= 1'b0;
			temp_cond_q       <= 1'b0;
			open_cond_q       <= 1'b0;
			last_voltage_ok_q <= 1'b1;
			last_temp_ok_q    <= 1'b1;
			comm_lost_q       <= 1'b0;
			comm_lost_ticks_q <= '0;
			for (int i = 0; i < CNT_NUM; i++)
				cnt_q[i] <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= valid_s1;
			if (advance && valid_s1) begin
				voltage_cond_q    <= voltage_cond_n;
				temp_cond_q       <= temp_cond_n;
				open_cond_q       <= open_cond_n;
				last_voltage_ok_q <= last_voltage_ok_n;
				last_temp_ok_q    <= last_temp_ok_n;
				comm_lost_q       <= comm_lost_n;
				comm_lost_ticks_q <= comm_lost_ticks_n;
				for (int i = 0; i < CNT_NUM; i++)
					cnt_q[i] <= cnt_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= in_data;
		if (advance && valid_s1)
			out_q <= res;
	end

	a_reinit_comm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.reinit_request |-> comm_lost_q)
		else $error("reinit pulse without comm loss episode");

	a_fault_comm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fault_comm |-> comm_lost_q)
		else $error("comm fault while comm not lost");

	a_comm_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		!comm_lost_q |-> comm_lost_ticks_q == '0)
		else $error("comm timer running outside an episode");

	a_volt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!voltage_cond_q |-> cnt_q[CNT_VOLT] == '0)
		else $error("voltage debounce count without condition");

	a_open_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!open_cond_q |-> cnt_q[CNT_OPEN] == '0)
		else $error("open sensor debounce count without condition");

endmodule
